/* sv/etfi_pkg.sv */
// Package for the escape-time fractal iterator.
// Holds the sequencer state type, register index codes and saturation helper.
// No dependencies.
package etfi_pkg;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQ_R   = 6'b000010,
    ST_SQ_I   = 6'b000100,
    ST_CROSS  = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_JULIA_MODE     = 2'd0,
    REG_MAX_ITERATIONS = 2'd1,
    REG_JULIA_C_REAL   = 2'd2,
    REG_JULIA_C_IMAG   = 2'd3
  } reg_index_t;

  localparam int unsigned ComponentWidth = 32;
  localparam int unsigned ProductWidth   = 64;
  localparam int unsigned LimitWidth     = 16;

  localparam logic signed [ProductWidth-1:0] CompMax = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ProductWidth-1:0] CompMin = -64'sh0000_0000_8000_0000;

  // Clamp a wide signed value into the 32-bit signed component range
  function automatic logic signed [ComponentWidth-1:0] sat_comp(
    input logic signed [ProductWidth-1:0] v
  );
    logic signed [ComponentWidth-1:0] r;
    if (v > CompMax) begin
      r = CompMax[ComponentWidth-1:0];
    end else if (v < CompMin) begin
      r = CompMin[ComponentWidth-1:0];
    end else begin
      r = v[ComponentWidth-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/escape_time_fractal_iterator_top.sv */
// Escape-time fractal iterator, top level.
// Depends on etfi_pkg for state type, register codes and saturation.
// One shared 32x32 signed multiplier under a small sequencer.
//
// Takes one point (point_real, point_imag, signed fixed point with FRACTION_BITS
// fraction bits) per request and returns how many iterations of z = z*z + c
// were done before |z|^2 reached 4.0 or the count reached max_iterations
// (capped at the largest COUNT_WIDTH-bit value). Mandelbrot mode starts z at 0
// with c the point; Julia mode starts z at the point with c from julia_c_real
// and julia_c_imag. Each iteration forms three products
// (zr*zr, zi*zi, zr*zi) through the single shared multiplier, then an
// update step tests escape and forms the new z with rounding and saturation.
// The escaping iteration still forms its products before the test, and a
// zero limit skips iteration. The default limit is 256. One point is in
// work at a time; in_stall stays high until its result has moved to the
// output register, which then waits for the receiver on its own. The next
// request is taken after that handoff. A blocked output register holds the
// finished point back for as long as the receiver stalls.
module escape_time_fractal_iterator_top
  import etfi_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 28,
  parameter int unsigned COUNT_WIDTH   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [31:0]     point_real,
  input  logic signed [31:0]     point_imag,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COUNT_WIDTH-1:0] iteration_count
);

  localparam int unsigned ThrShift  = 2 * FRACTION_BITS + 2;
  localparam bit          CanEscape = (ThrShift < ProductWidth);
  localparam logic [ProductWidth-1:0] Threshold =
    CanEscape ? (64'd1 << ThrShift) : '0;
  localparam logic signed [ProductWidth-1:0] HalfReal = 64'sd1 <<< (FRACTION_BITS - 1);
  localparam logic signed [ProductWidth-1:0] HalfImag = 64'sd1 <<< (FRACTION_BITS - 2);
  localparam int unsigned LimW = (COUNT_WIDTH > LimitWidth) ? COUNT_WIDTH : LimitWidth;
  localparam logic [LimW-1:0] CountMax = LimW'({COUNT_WIDTH{1'b1}});

  // Configuration registers
  logic                     julia_mode;
  logic [LimitWidth-1:0]    max_iterations;
  logic signed [31:0]       julia_c_real;
  logic signed [31:0]       julia_c_imag;

  // Sequencer and datapath registers
  state_t                   state;
  logic [COUNT_WIDTH-1:0]   iter;
  logic signed [31:0]       zr;
  logic signed [31:0]       zi;
  logic signed [31:0]       cr;
  logic signed [31:0]       ci;
  logic signed [63:0]       p_rr;
  logic signed [63:0]       p_ii;
  logic signed [63:0]       p_ri;
  logic signed [63:0]       rnd_r;
  logic [63:0]              mag;

  // Combinational signals
  logic [LimW-1:0]          lim_ext;
  logic [COUNT_WIDTH-1:0]   limit;
  logic signed [31:0]       mul_a;
  logic signed [31:0]       mul_b;
  logic signed [63:0]       prod;
  logic                     escape;
  logic signed [63:0]       sum_r;
  logic signed [63:0]       rnd_i;
  logic signed [63:0]       sum_i;
  logic [COUNT_WIDTH-1:0]   iter_next;
  logic                     in_accept;

  // Cap the limit at what the count can hold
  assign lim_ext = (LimW'(max_iterations) > CountMax) ? CountMax : LimW'(max_iterations);
  assign limit   = lim_ext[COUNT_WIDTH-1:0];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      julia_mode     <= 1'b0;
      max_iterations <= 16'd256;
      julia_c_real   <= '0;
      julia_c_imag   <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_JULIA_MODE:     julia_mode     <= cfg_data[0];
        REG_MAX_ITERATIONS: max_iterations <= cfg_data[LimitWidth-1:0];
        REG_JULIA_C_REAL:   julia_c_real   <= cfg_data;
        REG_JULIA_C_IMAG:   julia_c_imag   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Select operands for the shared multiplier
  always_comb begin
    case (state)
      ST_SQ_R: begin
        mul_a = zr;
        mul_b = zr;
      end
      ST_SQ_I: begin
        mul_a = zi;
        mul_b = zi;
      end
      default: begin
        mul_a = zr;
        mul_b = zi;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Escape test and new components
  assign escape    = CanEscape && (mag >= Threshold);
  assign sum_r     = (rnd_r >>> FRACTION_BITS) + 64'(cr);
  assign rnd_i     = p_ri + HalfImag;
  assign sum_i     = (rnd_i >>> (FRACTION_BITS - 1)) + 64'(ci);
  assign iter_next = iter + 1'b1;

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (julia_mode) begin
            zr <= point_real;
            zi <= point_imag;
            cr <= julia_c_real;
            ci <= julia_c_imag;
          end else begin
            zr <= '0;
            zi <= '0;
            cr <= point_real;
            ci <= point_imag;
          end
        end
      end
      ST_SQ_R:  p_rr <= prod;
      ST_SQ_I:  p_ii <= prod;
      ST_CROSS: begin
        p_ri  <= prod;
        mag   <= 64'(p_rr) + 64'(p_ii);
        rnd_r <= p_rr - p_ii + HalfReal;
      end
      ST_UPDATE: begin
        if (!escape) begin
          zr <= sat_comp(sum_r);
          zi <= sat_comp(sum_i);
        end
      end
      default: ;
    endcase
  end

  // Sequencer, count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the taken result unless the handoff reloads the register now
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            iter  <= '0;
            state <= (limit == '0) ? ST_DONE : ST_SQ_R;
          end
        end
        ST_SQ_R:  state <= ST_SQ_I;
        ST_SQ_I:  state <= ST_CROSS;
        ST_CROSS: state <= ST_UPDATE;
        ST_UPDATE: begin
          if (escape) begin
            state <= ST_DONE;
          end else begin
            iter  <= iter_next;
            state <= (iter_next == limit) ? ST_DONE : ST_SQ_R;
          end
        end
        ST_DONE: begin
          // hand off once the output register is free
          if (!out_valid || !out_stall) begin
            iteration_count <= iter;
            out_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // The count never runs past the limit while a point is in work
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (iter <= limit))
    else $error("iteration count exceeds limit");

  // A new result only appears from the handoff state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result appeared outside handoff");

  // A zero limit goes straight to handoff
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && (limit == '0)) |=> (state == ST_DONE))
    else $error("zero limit did not skip iteration");

  // Hold the finished count while the output register is blocked
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && out_stall) |=> (state == ST_DONE && out_valid))
    else $error("finished count lost while output blocked");
`endif

endmodule

/* tb/tb.sv */
// Testbench for escape_time_fractal_iterator_top: a directed table of points, then random phases.
// Counts are checked against typed table values or a fixed-point escape-time predictor kept here.
// Depends on etfi_pkg and the iterator RTL.
`timescale 1ns / 1ps

module tb
  import etfi_pkg::*;
();

  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned CNT_BITS  = 16;
  localparam int unsigned CNT_MAX   = (1 << CNT_BITS) - 1;
  // |z|^2 of 4.0 at the scale of a full product
  localparam logic [63:0] ESCAPE_MAG = 64'd1 << (2 * FRAC_BITS + 2);
  localparam longint COMP_HI = 64'sd2147483647;
  localparam longint COMP_LO = -64'sd2147483648;

  localparam longint CYCLE_LIMIT      = 20_000_000;
  localparam int     HOLD_CYCLES      = 400;
  localparam int     DRAIN_CYCLES     = 20;
  localparam int     RANDOM_PHASES    = 15;
  localparam int     POINTS_PER_PHASE = 107;
  localparam int     N_PROBES         = 24;

  localparam logic signed [31:0] Q_ZERO    = 32'sh0000_0000;
  localparam logic signed [31:0] Q_QUARTER = 32'sh0400_0000;
  localparam logic signed [31:0] Q_ONE     = 32'sh1000_0000;
  localparam logic signed [31:0] Q_TWO     = 32'sh2000_0000;
  localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
  localparam logic [31:0]        WINDOW    = 32'h2400_0000;  // 2.25
  localparam logic [31:0]        C_WINDOW  = 32'h0CCC_CCCD;  // 0.8

  // One directed request with the register setting it runs under
  typedef struct packed {
    logic                  julia;
    logic [15:0]           iter_limit;
    logic signed [31:0]    c_re;
    logic signed [31:0]    c_im;
    logic signed [31:0]    p_re;
    logic signed [31:0]    p_im;
    logic                  typed;
    logic [CNT_BITS-1:0]   count;
  } probe_t;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [1:0]          cfg_index;
  logic [31:0]         cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic signed [31:0]  point_real;
  logic signed [31:0]  point_imag;
  logic                out_valid;
  logic                out_stall;
  logic [CNT_BITS-1:0] iteration_count;

  // Register values as last written, reset values to start
  logic               sh_julia = 1'b0;
  logic [15:0]        sh_limit = 16'd256;
  logic signed [31:0] sh_c_re  = 32'sh0;
  logic signed [31:0] sh_c_im  = 32'sh0;

  logic [CNT_BITS-1:0] count_q[$];
  int     n_errors  = 0;
  int     n_results = 0;
  bit     gaps_on   = 1'b1;
  int     hold_asks = 0;
  longint cycles    = 0;

  // Directed points: extremes, both modes, zero and unit limits, saturation, escape boundary
  probe_t probes [N_PROBES] = '{
    '{1'b0, 16'd256, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 16'd256},
    '{1'b0, 16'd256, Q_ZERO, Q_ZERO, Q_TWO, Q_ZERO, 1'b1, 16'd1},
    '{1'b0, 16'd256, Q_ZERO, Q_ZERO, -Q_TWO, Q_ZERO, 1'b1, 16'd1},
    '{1'b0, 16'd256, Q_ZERO, Q_ZERO, Q_MAX, Q_MAX, 1'b1, 16'd1},
    '{1'b0, 16'd256, Q_ZERO, Q_ZERO, Q_MIN, Q_MIN, 1'b1, 16'd1},
    '{1'b0, 16'd256, Q_ZERO, Q_ZERO, Q_QUARTER, Q_ZERO, 1'b0, 16'd0},
    '{1'b0, 16'd256, Q_ZERO, Q_ZERO, 32'shF400_0000, 32'sh0199_999A, 1'b0, 16'd0},
    '{1'b0, 16'd256, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, 1'b0, 16'd0},
    '{1'b0, 16'd256, Q_ZERO, Q_ZERO, 32'shFFFF_FFFF, 32'sh0000_0001, 1'b0, 16'd0},
    '{1'b0, 16'd0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 16'd0},
    '{1'b0, 16'd0, Q_ZERO, Q_ZERO, Q_MAX, Q_MIN, 1'b1, 16'd0},
    '{1'b0, 16'd1, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 16'd1},
    '{1'b1, 16'd256, Q_ZERO, Q_ZERO, Q_MAX, Q_MAX, 1'b1, 16'd0},
    '{1'b1, 16'd256, Q_ZERO, Q_ZERO, Q_TWO, Q_ZERO, 1'b1, 16'd0},
    '{1'b1, 16'd256, Q_ZERO, Q_ZERO, Q_ZERO, -Q_TWO, 1'b1, 16'd0},
    '{1'b1, 16'd256, Q_ZERO, Q_ZERO, 32'sh1FFF_FFFF, Q_ZERO, 1'b0, 16'd0},
    '{1'b1, 16'd256, Q_ZERO, Q_ZERO, Q_MIN, Q_ZERO, 1'b1, 16'd0},
    '{1'b1, 16'd256, -Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 16'd256},
    '{1'b1, 16'd256, Q_MAX, Q_ZERO, 32'sh1E66_6666, Q_ZERO, 1'b0, 16'd0},
    '{1'b1, 16'd256, Q_MIN, Q_ZERO, Q_ZERO, 32'sh1E66_6666, 1'b0, 16'd0},
    '{1'b1, 16'd256, Q_ZERO, Q_MAX, 32'sh16A0_9E66, 32'sh16A0_9E66, 1'b0, 16'd0},
    '{1'b1, 16'd256, 32'shF333_3333, 32'sh027E_F9DB, 32'sh0199_999A, 32'sh0199_999A,
      1'b0, 16'd0},
    '{1'b1, 16'd65535, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 16'd65535},
    '{1'b0, 16'd65535, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, 1'b1, 16'd2}
  };

  escape_time_fractal_iterator_top #(
    .FRACTION_BITS(FRAC_BITS),
    .COUNT_WIDTH  (CNT_BITS)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .point_real     (point_real),
    .point_imag     (point_imag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .iteration_count(iteration_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp to the signed 32-bit component range
  function automatic longint clamp_comp(input longint v);
    if (v > COMP_HI) return COMP_HI;
    if (v < COMP_LO) return COMP_LO;
    return v;
  endfunction

  // Shift right, rounding half toward plus infinity
  function automatic longint round_shr(input longint p, input int unsigned s);
    return (p + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Iterate z = z*z + c under the current register setting and return the count
  function automatic logic [CNT_BITS-1:0] escape_count(input logic signed [31:0] p_re,
                                                        input logic signed [31:0] p_im);
    longint      zr, zi, cr, ci, sq_re, sq_im, next_re;
    logic [63:0] mag;
    int unsigned n, lim;
    lim = (32'(sh_limit) > CNT_MAX) ? CNT_MAX : 32'(sh_limit);
    if (sh_julia) begin
      zr = longint'(p_re);
      zi = longint'(p_im);
      cr = longint'(sh_c_re);
      ci = longint'(sh_c_im);
    end else begin
      zr = 0;
      zi = 0;
      cr = longint'(p_re);
      ci = longint'(p_im);
    end
    n = 0;
    while (n < lim) begin
      sq_re = zr * zr;
      sq_im = zi * zi;
      mag   = sq_re + sq_im;
      if (mag >= ESCAPE_MAG) break;
      next_re = clamp_comp(round_shr(sq_re - sq_im, FRAC_BITS) + cr);
      zi      = clamp_comp(round_shr(zr * zi, FRAC_BITS - 1) + ci);
      zr      = next_re;
      n++;
    end
    return n[CNT_BITS-1:0];
  endfunction

  // Uniform value in [-half, half]
  function automatic logic signed [31:0] rand_coord(input logic [31:0] half);
    logic [31:0] u;
    u = $urandom_range(2 * half, 0);
    return u - half;
  endfunction

  // Drive one register write; the caller lowers the write enable after the last one
  task automatic put_reg(input reg_index_t idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Program every register, with junk above the narrow ones, and track the setting
  task automatic load_config(input logic julia, input logic [15:0] lim,
                             input logic signed [31:0] c_re, input logic signed [31:0] c_im);
    logic [31:0] junk;
    junk = $urandom;
    put_reg(REG_JULIA_MODE, {junk[31:1], julia});
    put_reg(REG_MAX_ITERATIONS, {junk[31:16], lim});
    put_reg(REG_JULIA_C_REAL, c_re);
    put_reg(REG_JULIA_C_IMAG, c_im);
    cfg_write <= 1'b0;
    sh_julia = julia;
    sh_limit = lim;
    sh_c_re  = c_re;
    sh_c_im  = c_im;
  endtask

  // Drop the request and hold until every expected count has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (count_q.size() != 0);
  endtask

  // Offer one point after an optional gap and queue its expected count on acceptance
  task automatic offer_point(input logic signed [31:0] p_re, input logic signed [31:0] p_im,
                             input bit typed, input logic [CNT_BITS-1:0] typed_count);
    while (gaps_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    point_real <= p_re;
    point_imag <= p_im;
    do @(posedge clk); while (in_stall !== 1'b0);
    count_q.push_back(typed ? typed_count : escape_count(p_re, p_im));
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the sender asks for one
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < 15);
      end
    end
  end

  // Compare each accepted count with the oldest expectation
  always @(posedge clk) begin : check_counts
    logic [CNT_BITS-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (count_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("%0t: unexpected count %0d (result %0d)", $time, iteration_count, n_results);
        end
      end else begin
        want = count_q.pop_front();
        if (iteration_count !== want) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("%0t: result %0d iteration_count expected %0d, got %0d",
                     $time, n_results, want, iteration_count);
          end
        end
      end
      n_results++;
    end
  end

  // Bound the run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus: reset, directed table, random phases, drain
  initial begin
    probe_t             row;
    logic               julia;
    logic [15:0]        lim;
    logic signed [31:0] c_re, c_im;
    int unsigned        pick;
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_index  <= REG_JULIA_MODE;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    point_real <= '0;
    point_imag <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk the table, reprogramming only when the setting changes
    foreach (probes[i]) begin
      row = probes[i];
      if (row.julia != sh_julia || row.iter_limit != sh_limit ||
          row.c_re != sh_c_re || row.c_im != sh_c_im) begin
        wait_idle();
        load_config(row.julia, row.iter_limit, row.c_re, row.c_im);
      end
      offer_point(row.p_re, row.p_im, row.typed, row.count);
    end

    // Random phases; phase 1 runs with no idling, phase 4 sees a long receiver hold-off
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      gaps_on = (ph != 1);
      julia   = 1'($urandom_range(1));
      lim     = ($urandom_range(99) < 85) ? 16'($urandom_range(40))
                                          : 16'($urandom_range(300, 41));
      pick    = $urandom_range(3);
      case (pick)
        0: begin
          c_re = $urandom;
          c_im = $urandom;
        end
        1: begin
          c_re = rand_coord(Q_TWO);
          c_im = rand_coord(Q_TWO);
        end
        default: begin
          c_re = rand_coord(C_WINDOW);
          c_im = rand_coord(C_WINDOW);
        end
      endcase
      load_config(julia, lim, c_re, c_im);
      for (int k = 0; k < POINTS_PER_PHASE; k++) begin
        if (ph == 4 && k == 20) hold_asks++;
        if ($urandom_range(99) < 80) begin
          offer_point(rand_coord(WINDOW), rand_coord(WINDOW), 1'b0, '0);
        end else begin
          offer_point($urandom, $urandom, 1'b0, '0);
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
